// File: design/lscd_pkg.sv
`timescale 1ns / 1ps
package lscd_pkg;

    localparam int NUM_PIXELS = 64;
    localparam int PIX_AW     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int COLOR_W  = 24;
    localparam int TIME_W   = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int SPEED_W  = 9;
    localparam int SPEED_SH = 9;
    localparam int PROD_W   = SPEED_W + CH_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_STEP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHG  = 3'd4;

    localparam logic [SPEED_W-1:0] SPEED_RST    = 9'd256;
    localparam logic [CH_W-1:0]    MIN_DIFF_RST = 8'd2;
    localparam logic [CH_W-1:0]    MAX_CHG_RST  = 8'd255;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [PIX_AW-1:0]  t_pix_addr;

endpackage

// File: design/lscd_in_if.sv
`timescale 1ns / 1ps
interface lscd_in_if
    import lscd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] pixel_pos;
    t_color             pixel_color;
    t_time              now_ms;

    modport source (output valid, func, pixel_pos, pixel_color, now_ms,
                    input ready);
    modport sink   (input valid, func, pixel_pos, pixel_color, now_ms,
                    output ready);
endinterface

// File: design/lscd_out_if.sv
`timescale 1ns / 1ps
interface lscd_out_if
    import lscd_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   changed;
    t_color read_color;

    modport source (output valid, changed, read_color, input ready);
    modport sink   (input valid, changed, read_color, output ready);
endinterface

// File: design/led_strip_color_diffusion.sv
`timescale 1ns / 1ps
// Pixel strip with write, read and timed diffusion step. A write word is answered at
// acceptance, a read after one registered memory read. A diffusion step that is due walks
// the strip through the single pixel memory read port, one pixel per cycle, computing the
// transfer of each neighbor pair in one shared transfer unit and writing each pixel back
// once its right-hand pair is known; the scan is followed by S_TAIL and S_FIN, which writes
// the last pixel and gives the result. Input is not ready while a word is in progress. A
// step that is not due yet is answered at acceptance with changed low. Configuration writes
// are taken at any time and must only be issued while the block is idle.
module led_strip_color_diffusion
    import lscd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lscd_in_if.sink               i_in,
    lscd_out_if.source            o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam t_pix_addr LAST_PIX = PIX_AW'(NUM_PIXELS - 1);

    function automatic logic [CH_W-1:0] xfer(
        input logic [CH_W-1:0]    left,
        input logic [CH_W-1:0]    right,
        input logic [SPEED_W-1:0] spd,
        input logic [CH_W-1:0]    min_d,
        input logic [CH_W-1:0]    max_c
    );
        logic              neg;
        logic [CH_W-1:0]   mag;
        logic [PROD_W-1:0] prod;
        logic [CH_W-1:0]   amt;
        neg  = left < right;
        mag  = neg ? (right - left) : (left - right);
        prod = PROD_W'(spd) * PROD_W'(mag);
        amt  = prod[PROD_W-1:SPEED_SH];
        if (amt > max_c) begin
            amt = max_c;
        end
        if (mag < min_d) begin
            amt = '0;
        end
        return neg ? CH_W'(~amt + 1'b1) : amt;
    endfunction

    logic [2:0]           r_state;
    t_pix_addr            r_ptr;
    logic                 r_dv;
    t_pix_addr            r_didx;
    t_color               r_left;
    t_color               r_in;
    logic                 r_any;
    t_time                r_now;
    t_color               r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_ok;
    t_color               r_mem [NUM_PIXELS];
    logic [NUM_PIXELS-1:0] r_vld;

    t_time                r_start;
    t_time                r_interval;
    logic [SPEED_W-1:0]   r_speed;
    logic [CH_W-1:0]      r_min_diff;
    logic [CH_W-1:0]      r_max_chg;
    t_time                r_last;

    logic                 r_out_valid;
    logic                 r_out_changed;
    t_color               r_out_color;

    logic                 acc;
    logic                 in_ok;
    t_pix_addr            in_addr;
    logic                 in_go;
    t_color               cur;
    t_color               xf;
    t_color               new_left;
    t_color               tail_pix;
    logic                 pair_act;
    logic                 mem_we;
    t_pix_addr            mem_waddr;
    t_color               mem_wdata;
    t_pix_addr            mem_raddr;

    assign i_in.ready       = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid      = r_out_valid;
    assign o_out.changed    = r_out_changed;
    assign o_out.read_color = r_out_color;

    always_comb begin
        acc      = i_in.valid && i_in.ready;
        in_ok    = 32'(i_in.pixel_pos) < 32'(NUM_PIXELS);
        in_addr  = PIX_AW'(i_in.pixel_pos);
        in_go    = (i_in.now_ms >= r_start) &&
                   ((i_in.now_ms - r_last) >= r_interval);
        cur      = r_rd_vld ? r_rd_data : '0;
        pair_act = r_dv && (r_didx != '0);
        for (int c = 0; c < NUM_CH; c++) begin
            xf[c*CH_W +: CH_W] = xfer(r_left[c*CH_W +: CH_W], cur[c*CH_W +: CH_W],
                                      r_speed, r_min_diff, r_max_chg);
            new_left[c*CH_W +: CH_W] = r_left[c*CH_W +: CH_W] - xf[c*CH_W +: CH_W]
                                       + r_in[c*CH_W +: CH_W];
            tail_pix[c*CH_W +: CH_W] = r_left[c*CH_W +: CH_W] + r_in[c*CH_W +: CH_W];
        end
    end

    // one write port shared by pixel writes, scan write-back and the tail pixel
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = in_addr;
        mem_wdata = i_in.pixel_color;
        priority if (r_state == S_IDLE && acc && i_in.func == FN_WRITE && in_ok) begin
            mem_we = 1'b1;
        end else if (pair_act) begin
            mem_we    = 1'b1;
            mem_waddr = r_didx - 1'b1;
            mem_wdata = new_left;
        end else if (r_state == S_FIN) begin
            mem_we    = 1'b1;
            mem_waddr = LAST_PIX;
            mem_wdata = tail_pix;
        end else begin
            mem_we = 1'b0;
        end
        mem_raddr = (r_state == S_SCAN) ? r_ptr : in_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[mem_raddr];
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
        end
    end

    // configuration and last step time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_interval <= '0;
            r_speed    <= SPEED_RST;
            r_min_diff <= MIN_DIFF_RST;
            r_max_chg  <= MAX_CHG_RST;
            r_last     <= '0;
        end else begin
            if (r_state == S_FIN && r_any) begin
                r_last <= r_now;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START: begin
                        r_start <= i_cfg_data;
                        r_last  <= i_cfg_data;
                    end
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_SPEED:    r_speed    <= i_cfg_data[SPEED_W-1:0];
                    CFG_MIN_DIFF: r_min_diff <= i_cfg_data[CH_W-1:0];
                    CFG_MAX_CHG:  r_max_chg  <= i_cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // scan datapath and request capture
    always_ff @(posedge i_clk) begin
        r_didx <= r_ptr;
        if (r_dv) begin
            r_left <= cur;
            r_in   <= pair_act ? xf : '0;
        end
        if (r_state == S_IDLE && acc) begin
            r_rd_ok <= in_ok;
            r_now   <= i_in.now_ms;
        end
    end

    // sequencer and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ptr         <= '0;
            r_dv          <= 1'b0;
            r_any         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_changed <= 1'b0;
            r_out_color   <= '0;
        end else begin
            r_dv <= (r_state == S_SCAN);
            if (pair_act && (xf != '0)) begin
                r_any <= 1'b1;
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (i_in.func == FN_READ) begin
                            r_state <= S_READ;
                        end else if (i_in.func == FN_STEP && in_go) begin
                            r_state <= S_SCAN;
                            r_ptr   <= '0;
                            r_any   <= 1'b0;
                        end else begin
                            r_out_valid   <= 1'b1;
                            r_out_changed <= 1'b0;
                            r_out_color   <= '0;
                        end
                    end
                end
                S_READ: begin
                    r_out_valid   <= 1'b1;
                    r_out_changed <= 1'b0;
                    r_out_color   <= r_rd_ok ? cur : '0;
                    r_state       <= S_IDLE;
                end
                S_SCAN: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == LAST_PIX) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_out_valid   <= 1'b1;
                    r_out_changed <= r_any;
                    r_out_color   <= '0;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_step_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.func == FN_STEP && in_go) |=> (r_state == S_SCAN && r_ptr == '0))
        else $error("due step did not start a scan");

    a_fin_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_out.valid && o_out.changed == $past(r_any)))
        else $error("step finished without its result word");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_TAIL || r_state == S_FIN) |-> !i_in.ready)
        else $error("input taken during a step");

    a_last_time_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_last)) |->
            ($past(i_cfg_we) || $past(r_state == S_FIN && r_any)))
        else $error("last step time moved without a change or config write");

    a_no_write_idle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_ptr == '0) |-> !pair_act)
        else $error("write-back active at scan start");

endmodule

// File: sim/tb_led_strip_color_diffusion.sv
`timescale 1ns / 1ps
module tb_led_strip_color_diffusion;
    import lscd_pkg::*;

    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic   changed;
        t_color read_color;
    } t_result;

    class diffusion_scoreboard;
        t_color             pixels [NUM_PIXELS];
        t_time              start_time;
        t_time              step_interval;
        t_time              last_step;
        logic [SPEED_W-1:0] speed;
        logic [CH_W-1:0]    min_diff;
        logic [CH_W-1:0]    max_chg;
        t_result            expected_words [$];
        int                 errors;

        function new();
            foreach (pixels[i]) pixels[i] = '0;
            start_time    = '0;
            step_interval = '0;
            last_step     = '0;
            speed         = SPEED_RST;
            min_diff      = MIN_DIFF_RST;
            max_chg       = MAX_CHG_RST;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_START: begin
                    start_time = data;
                    last_step  = data;
                end
                CFG_INTERVAL: step_interval = data;
                CFG_SPEED:    speed = data[SPEED_W-1:0];
                CFG_MIN_DIFF: min_diff = data[CH_W-1:0];
                CFG_MAX_CHG:  max_chg = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        // signed amount moved from left to right in one channel
        function int channel_flow(int left, int right);
            int d;
            int mag;
            int t;
            d   = left - right;
            mag = (d < 0) ? -d : d;
            if (mag < int'(min_diff))
                return 0;
            t = (int'(speed) * mag) / (1 << SPEED_SH);
            if (t > int'(max_chg))
                t = int'(max_chg);
            return (d < 0) ? -t : t;
        endfunction

        function bit diffuse();
            t_color          snap [NUM_PIXELS];
            t_color          after [NUM_PIXELS];
            int              flow [NUM_CH];
            int              sh;
            bit              any_flow;
            bit              moved;
            logic [CH_W-1:0] amt;
            snap  = pixels;
            after = pixels;
            moved = 1'b0;
            for (int i = 0; i + 1 < NUM_PIXELS; i++) begin
                if (snap[i] == snap[i+1])
                    continue;
                any_flow = 1'b0;
                for (int c = 0; c < NUM_CH; c++) begin
                    sh = (NUM_CH - 1 - c) * CH_W;
                    flow[c] = channel_flow(int'(snap[i][sh +: CH_W]),
                                           int'(snap[i+1][sh +: CH_W]));
                    if (flow[c] != 0)
                        any_flow = 1'b1;
                end
                if (!any_flow)
                    continue;
                for (int c = 0; c < NUM_CH; c++) begin
                    sh  = (NUM_CH - 1 - c) * CH_W;
                    amt = flow[c][CH_W-1:0];
                    after[i][sh +: CH_W]   = after[i][sh +: CH_W] - amt;
                    after[i+1][sh +: CH_W] = after[i+1][sh +: CH_W] + amt;
                end
                moved = 1'b1;
            end
            if (moved)
                pixels = after;
            return moved;
        endfunction

        function void note_word(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                                t_color color, t_time now);
            t_result r;
            r = '0;
            case (func)
                FN_WRITE: begin
                    if (int'(idx) < NUM_PIXELS)
                        pixels[idx] = color;
                end
                FN_STEP: begin
                    if (now >= start_time && t_time'(now - last_step) >= step_interval) begin
                        if (diffuse()) begin
                            r.changed = 1'b1;
                            last_step = now;
                        end
                    end
                end
                FN_READ: begin
                    if (int'(idx) < NUM_PIXELS)
                        r.read_color = pixels[idx];
                end
                default: ;
            endcase
            expected_words.push_back(r);
        endfunction

        function void check_word(logic changed, t_color read_color);
            t_result exp_word;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: changed %0d read_color %06h",
                       changed, read_color);
                errors++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (changed !== exp_word.changed) begin
                $error("changed: expected %0d, got %0d", exp_word.changed, changed);
                errors++;
            end
            if (read_color !== exp_word.read_color) begin
                $error("read_color: expected %06h, got %06h", exp_word.read_color, read_color);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit calm;

    diffusion_scoreboard sb = new();

    lscd_in_if  in_if ();
    lscd_out_if out_if ();

    led_strip_color_diffusion u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_word(out_if.changed, out_if.read_color);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("led_strip_color_diffusion regression: fail");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                             t_color color, t_time now);
        while (!calm && $urandom_range(0, 99) < 30) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.func        <= func;
        in_if.pixel_pos   <= idx;
        in_if.pixel_color <= color;
        in_if.now_ms      <= now;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_word(func, idx, color, now);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic setup(t_time st, t_time iv, int sp, int md, int mc);
        settle();
        cfg_write(CFG_START, st);
        cfg_write(CFG_INTERVAL, iv);
        cfg_write(CFG_SPEED, sp);
        cfg_write(CFG_MIN_DIFF, md);
        cfg_write(CFG_MAX_CHG, mc);
        // unused indexes must leave every register alone
        for (int k = int'(CFG_MAX_CHG) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), $urandom);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_color pick_color(int idx);
        int     roll;
        t_color base;
        t_color c;
        roll = $urandom_range(0, 99);
        base = sb.pixels[(idx == 0) ? 1 : idx - 1];
        c    = t_color'($urandom);
        if (roll < 30) begin
            c = t_color'($urandom);
        end else if (roll < 60) begin
            // near the neighbor so thresholds and small transfers get hit
            for (int k = 0; k < NUM_CH; k++)
                c[k*CH_W +: CH_W] = base[k*CH_W +: CH_W] + CH_W'($urandom_range(0, 8)) - 8'd4;
        end else if (roll < 75) begin
            c = base;
        end else if (roll < 85) begin
            c = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            for (int k = 0; k < NUM_CH; k++)
                c[k*CH_W +: CH_W] = $urandom_range(0, 1) ? '1 : '0;
        end
        return c;
    endfunction

    function automatic t_time pick_time();
        int    roll;
        t_time due;
        roll = $urandom_range(0, 99);
        due  = sb.last_step + sb.step_interval;
        if (roll < 70)
            return due + $urandom_range(0, 40);
        if (roll < 80)
            return due - $urandom_range(1, 4);
        if (roll < 90)
            return sb.start_time - $urandom_range(1, 10);
        return $urandom;
    endfunction

    task automatic random_word();
        int                 roll;
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        t_time              now;
        roll = $urandom_range(0, 99);
        idx  = INDEX_W'($urandom_range(0, NUM_PIXELS - 1));
        if (roll < 40)
            func = FN_WRITE;
        else if (roll < 72)
            func = FN_STEP;
        else if (roll < 95)
            func = FN_READ;
        else
            func = FN_NONE;
        now = (func == FN_STEP) ? pick_time() : t_time'($urandom);
        send_word(func, idx, pick_color(idx), now);
    endtask

    task automatic run_phase(int count, int calm_from, int calm_to);
        for (int n = 0; n < count; n++) begin
            calm = (n >= calm_from && n < calm_to);
            random_word();
        end
        calm = 1'b0;
    endtask

    initial begin
        calm              = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.func        = FN_WRITE;
        in_if.pixel_pos   = '0;
        in_if.pixel_color = '0;
        in_if.now_ms      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults after reset
        send_word(FN_READ, 0, 24'h123456, 0);
        send_word(FN_WRITE, 0, 24'hFFFFFF, 32'hFFFFFFFF);
        send_word(FN_WRITE, 1, 24'h00FF80, 0);
        send_word(FN_WRITE, INDEX_W'(NUM_PIXELS - 1), '1, 0);
        send_word(FN_WRITE, 62, '0, 0);
        send_word(FN_READ, 0, 0, 0);
        send_word(FN_READ, INDEX_W'(NUM_PIXELS - 1), 0, 0);
        send_word(FN_NONE, '1, '1, '1);
        send_word(FN_STEP, 0, 0, 0);
        send_word(FN_READ, 0, 0, 0);
        send_word(FN_READ, 1, 0, 0);
        send_word(FN_STEP, 0, 0, 32'hFFFFFFF8);
        // elapsed time wraps past zero
        send_word(FN_STEP, 0, 0, 32'h00000010);

        setup(0, 16, 511, 0, 1);
        send_word(FN_STEP, 0, 0, sb.last_step + 15);
        send_word(FN_STEP, 0, 0, sb.last_step + 16);
        send_word(FN_WRITE, 5, 24'h010101, 0);
        send_word(FN_STEP, 0, 0, sb.last_step + 16);
        send_word(FN_READ, 5, 0, 0);

        setup(32'hFFFFFFF0, 16, SPEED_RST, MIN_DIFF_RST, MAX_CHG_RST);
        send_word(FN_STEP, 0, 0, 5);
        send_word(FN_STEP, 0, 0, 32'hFFFFFFFF);
        send_word(FN_STEP, 0, 0, 0);

        setup(0, 0, SPEED_RST, MIN_DIFF_RST, MAX_CHG_RST);
        run_phase(350, 40, 140);
        setup(1000 + $urandom_range(0, 1000), $urandom_range(1, 100), 128, 0, 16);
        run_phase(250, 0, 0);
        setup($urandom, $urandom, 511, 255, 255);
        run_phase(150, 0, 0);
        setup(0, 0, 0, 0, 0);
        run_phase(100, 0, 0);
        setup($urandom, $urandom_range(0, 500), $urandom_range(257, 511),
              $urandom_range(0, 20), $urandom_range(1, 254));
        run_phase(350, 0, 0);
        setup(0, 32'hFFFFFFFF, $urandom_range(0, 511), $urandom_range(0, 255),
              $urandom_range(0, 255));
        run_phase(100, 0, 0);

        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (NUM_PIXELS + 8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("led_strip_color_diffusion regression: pass");
        else
            $display("led_strip_color_diffusion regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/lscd_pkg.sv
design/lscd_in_if.sv
design/lscd_out_if.sv
design/led_strip_color_diffusion.sv
sim/tb_led_strip_color_diffusion.sv
